// ===== rtl/core/utf8dec_pkg.sv =====
// Types and constants shared by the UTF-8 to UTF-16 decoder and its checker.
package utf8dec_pkg;

  localparam int unsigned UNIT_W   = 16;
  localparam int unsigned SCALAR_W = 21;
  localparam int unsigned RES_Q_DEPTH = 4;
  localparam int unsigned RES_Q_AW    = $clog2(RES_Q_DEPTH);

  // Configuration register indexes (byte address divided by four).
  localparam logic REG_FATAL_MODE = 1'b0;
  localparam logic REG_KEEP_BOM   = 1'b1;

  localparam logic [SCALAR_W-1:0] BOM_CP    = 21'h00_FEFF;
  localparam logic [SCALAR_W-1:0] REPL_CP   = 21'h00_FFFD;
  localparam logic [SCALAR_W-1:0] SUPP_BASE = 21'h01_0000;
  localparam logic [UNIT_W-1:0]   HI_SURR   = 16'hD800;
  localparam logic [UNIT_W-1:0]   LO_SURR   = 16'hDC00;

  localparam logic [7:0] ASCII_END  = 8'h80;
  localparam logic [7:0] CONT_LO    = 8'h80;
  localparam logic [7:0] CONT_HI    = 8'hBF;
  localparam logic [7:0] LEAD2_LO   = 8'hC2;
  localparam logic [7:0] LEAD2_HI   = 8'hDF;
  localparam logic [7:0] LEAD3_LO   = 8'hE0;
  localparam logic [7:0] LEAD3_HI   = 8'hEF;
  localparam logic [7:0] LEAD3_SURR = 8'hED;
  localparam logic [7:0] LEAD4_LO   = 8'hF0;
  localparam logic [7:0] LEAD4_HI   = 8'hF4;
  localparam logic [7:0] E0_LO      = 8'hA0;
  localparam logic [7:0] ED_HI      = 8'h9F;
  localparam logic [7:0] F0_LO      = 8'h90;
  localparam logic [7:0] F4_HI      = 8'h8F;

  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    logic              unit_present;
    logic              fatal_error;
    logic              last_of_message;
  } utf8dec_res_t;

  typedef struct packed {
    logic [SCALAR_W-1:0] partial;
    logic [1:0]          needed;
    logic [1:0]          seen;
    logic [7:0]          lo_bound;
    logic [7:0]          hi_bound;
    logic                msg_start;
    logic                err_latched;
  } utf8dec_state_t;

  typedef struct packed {
    utf8dec_state_t st;
    utf8dec_res_t   r0;
    utf8dec_res_t   r1;
    logic [1:0]     cnt;
  } utf8dec_step_t;

endpackage

// ===== rtl/core/utf8_to_utf16_decoder_unit.sv =====
// Streaming UTF-8 to UTF-16 decoder with WHATWG error handling and APB configuration.
//
//  channel  | ports                          | payload
//  ---------+--------------------------------+-------------------------------------------
//  input    | in_tvalid/in_tready            | tdata = data_byte, tlast = end_of_message
//  result   | out_tvalid/out_tready          | tdata = code_unit, tuser = flags, tlast = last
//  config   | cfg_psel/penable/pwrite/paddr  | reg 0 fatal_mode @0x0, reg 1 keep_bom @0x4
//
// One byte is decoded per cycle, while in_tready is high, in a single registered pass;
// its zero, one or two results go into a four-entry result queue, and a byte producing
// two results (surrogate pair) writes both at once, which leave the queue one by one.
// in_tready is high while the queue has room for two results, so it does not depend
// on out_tready in the same cycle. Reset (rst_n low, synchronous) empties the queue
// and returns the decoder to the start of a message.
module utf8_to_utf16_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [15:0] code_unit
  output logic [1:0]  out_tuser,   // [0] unit_present, [1] fatal_error
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import utf8dec_pkg::*;

  logic           fatal_mode_r;
  logic           keep_bom_r;
  utf8dec_state_t state_r;
  utf8dec_step_t  step;
  logic           in_xfer;
  logic           out_xfer;
  logic           cfg_wr;

  utf8dec_res_t          res_q_r [RES_Q_DEPTH];
  logic [RES_Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [RES_Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [RES_Q_AW:0]     count_r, count_nxt;
  logic [RES_Q_AW:0]     push_n;

  // ---------------------------------------------------------------------------
  // Decoder step helpers
  // ---------------------------------------------------------------------------
  function automatic utf8dec_step_t push(utf8dec_step_t s, logic [UNIT_W-1:0] unit,
                                         logic present, logic fatal);
    utf8dec_res_t r;
    r.code_unit       = unit;
    r.unit_present    = present;
    r.fatal_error     = fatal;
    r.last_of_message = 1'b0;
    if (s.cnt == 2'd0) begin
      s.r0  = r;
      s.cnt = 2'd1;
    end else if (s.cnt == 2'd1) begin
      s.r1  = r;
      s.cnt = 2'd2;
    end
    return s;
  endfunction

  function automatic utf8dec_step_t emit_scalar(utf8dec_step_t s, logic [SCALAR_W-1:0] cp,
                                                logic kb);
    logic [19:0] v;
    v = 20'(cp - SUPP_BASE);
    if (s.st.msg_start && !kb && cp == BOM_CP) begin
      s.st.msg_start = 1'b0;
    end else begin
      s.st.msg_start = 1'b0;
      if (cp < SUPP_BASE) begin
        s = push(s, cp[UNIT_W-1:0], 1'b1, 1'b0);
      end else begin
        s = push(s, HI_SURR + {6'd0, v[19:10]}, 1'b1, 1'b0);
        s = push(s, LO_SURR + {6'd0, v[9:0]}, 1'b1, 1'b0);
      end
    end
    return s;
  endfunction

  function automatic utf8dec_step_t clear_seq(utf8dec_step_t s);
    s.st.partial  = '0;
    s.st.needed   = 2'd0;
    s.st.seen     = 2'd0;
    s.st.lo_bound = CONT_LO;
    s.st.hi_bound = CONT_HI;
    return s;
  endfunction

  function automatic utf8dec_step_t report_error(utf8dec_step_t s, logic fm, logic kb);
    if (fm) begin
      s.st.err_latched = 1'b1;
      s = push(s, '0, 1'b0, 1'b1);
    end else begin
      s = emit_scalar(s, REPL_CP, kb);
    end
    return s;
  endfunction

  function automatic utf8dec_step_t start_seq(utf8dec_step_t s, logic [7:0] b,
                                              logic fm, logic kb);
    if (b < ASCII_END) begin
      s = emit_scalar(s, {13'd0, b}, kb);
    end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
      s.st.needed  = 2'd1;
      s.st.partial = {16'd0, b[4:0]};
    end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
      if (b == LEAD3_LO)   s.st.lo_bound = E0_LO;
      if (b == LEAD3_SURR) s.st.hi_bound = ED_HI;
      s.st.needed  = 2'd2;
      s.st.partial = {17'd0, b[3:0]};
    end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
      if (b == LEAD4_LO) s.st.lo_bound = F0_LO;
      if (b == LEAD4_HI) s.st.hi_bound = F4_HI;
      s.st.needed  = 2'd3;
      s.st.partial = {18'd0, b[2:0]};
    end else begin
      s = report_error(s, fm, kb);
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // One byte through the decoder
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [SCALAR_W-1:0] cp;
    logic [7:0]          b;
    b       = in_tdata;
    cp      = '0;
    step    = '0;
    step.st = state_r;

    if (!step.st.err_latched) begin
      if (step.st.needed == 2'd0) begin
        step = start_seq(step, b, fatal_mode_r, keep_bom_r);
      end else if (b < step.st.lo_bound || b > step.st.hi_bound) begin
        // The broken sequence yields one error, then, unless fatal mode latched it, the byte is retried as a leader.
        step = clear_seq(step);
        step = report_error(step, fatal_mode_r, keep_bom_r);
        if (!step.st.err_latched) begin
          step = start_seq(step, b, fatal_mode_r, keep_bom_r);
        end
      end else begin
        step.st.lo_bound = CONT_LO;
        step.st.hi_bound = CONT_HI;
        step.st.partial  = {step.st.partial[SCALAR_W-7:0], b[5:0]};
        step.st.seen     = step.st.seen + 2'd1;
        if (step.st.seen == step.st.needed) begin
          cp   = step.st.partial;
          step = clear_seq(step);
          step = emit_scalar(step, cp, keep_bom_r);
        end
      end
    end

    if (in_tlast) begin
      if (!step.st.err_latched && step.st.needed != 2'd0) begin
        step = clear_seq(step);
        step = report_error(step, fatal_mode_r, keep_bom_r);
      end
      if (step.cnt == 2'd0) begin
        step = push(step, '0, 1'b0, step.st.err_latched);
      end
      if (step.cnt == 2'd2) begin
        step.r1.last_of_message = 1'b1;
      end else begin
        step.r0.last_of_message = 1'b1;
      end
      step                = clear_seq(step);
      step.st.msg_start   = 1'b1;
      step.st.err_latched = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Decoder state and configuration registers
  // ---------------------------------------------------------------------------
  assign in_xfer  = in_tvalid && in_tready;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.partial     <= '0;
      state_r.needed      <= 2'd0;
      state_r.seen        <= 2'd0;
      state_r.lo_bound    <= CONT_LO;
      state_r.hi_bound    <= CONT_HI;
      state_r.msg_start   <= 1'b1;
      state_r.err_latched <= 1'b0;
      fatal_mode_r        <= 1'b0;
      keep_bom_r          <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_r <= step.st;
      end
      if (cfg_wr) begin
        case (cfg_paddr[2])
          REG_FATAL_MODE: fatal_mode_r <= cfg_pwdata[0];
          REG_KEEP_BOM:   keep_bom_r   <= cfg_pwdata[0];
          default: ;
        endcase
      end
    end
  end

  assign cfg_pready = 1'b1;

  always_comb begin
    cfg_prdata = '0;
    case (cfg_paddr[2])
      REG_FATAL_MODE: cfg_prdata[0] = fatal_mode_r;
      REG_KEEP_BOM:   cfg_prdata[0] = keep_bom_r;
      default:        cfg_prdata    = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------------------
  assign in_tready  = count_r <= (RES_Q_AW+1)'(RES_Q_DEPTH - 2);
  assign out_tvalid = count_r != '0;
  assign out_xfer   = out_tvalid && out_tready;

  assign push_n     = in_xfer ? (RES_Q_AW+1)'(step.cnt) : '0;
  assign wr_ptr_nxt = wr_ptr_r + push_n[RES_Q_AW-1:0];
  assign rd_ptr_nxt = out_xfer ? rd_ptr_r + RES_Q_AW'(1) : rd_ptr_r;
  assign count_nxt  = count_r + push_n - (out_xfer ? (RES_Q_AW+1)'(1) : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && step.cnt != 2'd0) begin
      res_q_r[wr_ptr_r] <= step.r0;
    end
    if (in_xfer && step.cnt == 2'd2) begin
      res_q_r[wr_ptr_r + RES_Q_AW'(1)] <= step.r1;
    end
  end

  assign out_tdata = res_q_r[rd_ptr_r].code_unit;
  assign out_tuser = {res_q_r[rd_ptr_r].fatal_error, res_q_r[rd_ptr_r].unit_present};
  assign out_tlast = res_q_r[rd_ptr_r].last_of_message;

endmodule

// ===== rtl/core/utf8dec_checker.sv =====
// Port-level checks for the UTF-8 to UTF-16 decoder, bound to the top level.
module utf8dec_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  import utf8dec_pkg::*;

  // A result that is held back keeps its contents until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                   $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Reset leaves an empty result queue that can take input.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("result queue not empty after reset");

  // A fatal error result never carries a code unit.
  a_fatal_no_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[0] && out_tdata == '0)
    else $error("fatal result carries a unit");

  // A result without a unit is either a fatal error or the end marker.
  a_bare_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] && !out_tuser[1] |-> out_tlast && out_tdata == '0)
    else $error("bare result that is not an end marker");

endmodule

bind utf8_to_utf16_decoder_unit utf8dec_checker u_utf8dec_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);
